/* src/rbsi_pkg.sv */
package rbsi_pkg;

   localparam int COORD_FRAC_BITS_DEF = 16;
   localparam int DIR_FRAC_BITS = 16;

   localparam int COORD_W = 32;
   localparam int DIR_W = 18;
   localparam int RADIUS_W = 31;
   localparam int DIST_W = 33;
   localparam int DIFF_W = COORD_W + 1;
   localparam int MAG_W = COORD_W;
   localparam int DMAG_W = DIR_W;
   localparam int PARALLEL_MAX = 65;

   // box slab division
   localparam int NUM_W = MAG_W + DIR_FRAC_BITS;
   localparam int DIV_STEPS = NUM_W;
   localparam int T_W = 50;

   // sphere path
   localparam int PROD_W = DIFF_W + DIR_W;
   localparam int S_W = PROD_W + 2;
   localparam int MS_W = 52;
   localparam int HALF_W = MS_W / 2;
   localparam int SQ_W = 2 * MAG_W;
   localparam int L2_W = SQ_W + 2;
   localparam int R2_W = 2 * RADIUS_W;
   localparam int S2_W = 2 * MS_W;
   localparam int V_W = S2_W;
   localparam int ROOT_W = V_W / 2;
   localparam int SQRT_STEPS = ROOT_W;
   localparam int TS_W = S_W + 2;
   localparam int TSH_W = TS_W - DIR_FRAC_BITS;
   localparam int RS_SHIFT = 32;

   // pipeline stage numbers in the back end
   localparam int SPH_PRE = 7;
   localparam int ST_ROOT = SPH_PRE + SQRT_STEPS;
   localparam int BOX_PAD = ST_ROOT - DIV_STEPS;
   localparam int ST_LAST = ST_ROOT + 3;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = QPTR_W + 1;

   // register map
   localparam int REG_IDX_W = 3;
   localparam logic [REG_IDX_W-1:0] REG_SHAPE    = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_CORNER_AX = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_CORNER_AY = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_CORNER_AZ = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_CORNER_BX = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_CORNER_BY = 3'd5;
   localparam logic [REG_IDX_W-1:0] REG_CORNER_BZ = 3'd6;
   localparam logic [REG_IDX_W-1:0] REG_RADIUS   = 3'd7;
   localparam logic [RADIUS_W-1:0] RADIUS_RESET = 31'd65536;

   typedef struct packed {
      logic                         is_box;
      logic [2:0]                   par;
      logic                         par_miss;
      logic [2:0][DIR_W-1:0]        dir;
      logic [2:0][DIFF_W-1:0]       da;
      logic [2:0][DIFF_W-1:0]       db;
   } item_type;

   typedef struct packed {
      logic       vld;
      logic       is_box;
      logic [2:0] par;
      logic       par_miss;
   } tag_type;

   typedef struct packed {
      logic [DMAG_W-1:0] rem;
      logic [NUM_W-1:0]  nq;
      logic [DMAG_W-1:0] den;
      logic              neg;
   } div_lane_type;

   typedef struct packed {
      logic [ROOT_W+1:0] rem;
      logic [ROOT_W-1:0] root;
      logic [V_W-1:0]    v;
      logic [S_W-1:0]    s;
      logic              outside;
      logic              miss;
   } sqrt_type;

   function automatic logic [MAG_W-1:0] mag_diff(input logic [DIFF_W-1:0] x);
      logic [DIFF_W-1:0] n;
      n = x[DIFF_W-1] ? (~x + 1'b1) : x;
      return n[MAG_W-1:0];
   endfunction

   function automatic logic [DMAG_W-1:0] mag_dir(input logic [DIR_W-1:0] x);
      return x[DIR_W-1] ? (~x + 1'b1) : x;
   endfunction

   // one restoring division step, quotient bits shift in as numerator bits shift out
   function automatic div_lane_type div_step(input div_lane_type x);
      logic [DMAG_W:0] tmp;
      logic [DMAG_W:0] sub;
      div_lane_type    y;
      y = x;
      tmp = {x.rem, x.nq[NUM_W-1]};
      sub = tmp - {1'b0, x.den};
      if (tmp >= {1'b0, x.den}) begin
         y.rem = sub[DMAG_W-1:0];
         y.nq = {x.nq[NUM_W-2:0], 1'b1};
      end else begin
         y.rem = tmp[DMAG_W-1:0];
         y.nq = {x.nq[NUM_W-2:0], 1'b0};
      end
      return y;
   endfunction

   // one digit of the bitwise square root
   function automatic sqrt_type sqrt_step(input sqrt_type x);
      logic [ROOT_W+3:0] tmp;
      logic [ROOT_W+3:0] trial;
      logic [ROOT_W+3:0] sub;
      sqrt_type          y;
      y = x;
      tmp = {x.rem, x.v[V_W-1 -: 2]};
      trial = {2'b00, x.root, 2'b01};
      sub = tmp - trial;
      y.v = {x.v[V_W-3:0], 2'b00};
      if (tmp >= trial) begin
         y.rem = sub[ROOT_W+1:0];
         y.root = {x.root[ROOT_W-2:0], 1'b1};
      end else begin
         y.rem = tmp[ROOT_W+1:0];
         y.root = {x.root[ROOT_W-2:0], 1'b0};
      end
      return y;
   endfunction

endpackage

/* src/ray_box_sphere_intersect_top.sv */
// throughput: one ray per cycle while the result queue has room, set by the fully
// pipelined slab divider and square root
// a full result queue halts the whole back-end pipe; the front keeps taking rays into a
// four-entry queue meanwhile
// reset: synchronous, clears both queues and pipe valid bits and restores register defaults
module ray_box_sphere_intersect_top #(
   parameter int COORD_FRAC_BITS = rbsi_pkg::COORD_FRAC_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_push,
   output logic                             req_full,
   input  logic [rbsi_pkg::COORD_W-1:0]     req_origin_x,
   input  logic [rbsi_pkg::COORD_W-1:0]     req_origin_y,
   input  logic [rbsi_pkg::COORD_W-1:0]     req_origin_z,
   input  logic [rbsi_pkg::DIR_W-1:0]       req_dir_x,
   input  logic [rbsi_pkg::DIR_W-1:0]       req_dir_y,
   input  logic [rbsi_pkg::DIR_W-1:0]       req_dir_z,
   output logic                             rsp_empty,
   input  logic                             rsp_pop,
   output logic                             rsp_hit,
   output logic [rbsi_pkg::DIST_W-1:0]      rsp_distance,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [4:0]                       csr_paddr,
   input  logic [31:0]                      csr_pwdata,
   output logic [31:0]                      csr_prdata,
   output logic                             csr_pready
);

   logic                                  shape_is_box_ff, shape_is_box_in;
   logic [2:0][rbsi_pkg::COORD_W-1:0]     corner_a_ff, corner_a_in;
   logic [2:0][rbsi_pkg::COORD_W-1:0]     corner_b_ff, corner_b_in;
   logic [rbsi_pkg::RADIUS_W-1:0]         sphere_radius_ff, sphere_radius_in;
   logic                                  wr_en;
   logic [rbsi_pkg::REG_IDX_W-1:0]        reg_idx;

   logic                                  q_full, q_push, q_pop, q_empty;
   rbsi_pkg::item_type                    item, q_head;

   assign csr_pready = 1'b1;
   assign wr_en = csr_psel && csr_penable && csr_pwrite;
   assign reg_idx = csr_paddr[4:2];

   always_comb begin
      shape_is_box_in = shape_is_box_ff;
      corner_a_in = corner_a_ff;
      corner_b_in = corner_b_ff;
      sphere_radius_in = sphere_radius_ff;
      if (wr_en) begin
         case (reg_idx)
            rbsi_pkg::REG_SHAPE:     shape_is_box_in = csr_pwdata[0];
            rbsi_pkg::REG_CORNER_AX: corner_a_in[0] = csr_pwdata;
            rbsi_pkg::REG_CORNER_AY: corner_a_in[1] = csr_pwdata;
            rbsi_pkg::REG_CORNER_AZ: corner_a_in[2] = csr_pwdata;
            rbsi_pkg::REG_CORNER_BX: corner_b_in[0] = csr_pwdata;
            rbsi_pkg::REG_CORNER_BY: corner_b_in[1] = csr_pwdata;
            rbsi_pkg::REG_CORNER_BZ: corner_b_in[2] = csr_pwdata;
            rbsi_pkg::REG_RADIUS:    sphere_radius_in = csr_pwdata[rbsi_pkg::RADIUS_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shape_is_box_ff <= 1'b1;
         corner_a_ff <= '0;
         corner_b_ff <= '0;
         sphere_radius_ff <= rbsi_pkg::RADIUS_RESET;
      end else begin
         shape_is_box_ff <= shape_is_box_in;
         corner_a_ff <= corner_a_in;
         corner_b_ff <= corner_b_in;
         sphere_radius_ff <= sphere_radius_in;
      end
   end

   always_comb begin
      case (reg_idx)
         rbsi_pkg::REG_SHAPE:     csr_prdata = {31'd0, shape_is_box_ff};
         rbsi_pkg::REG_CORNER_AX: csr_prdata = corner_a_ff[0];
         rbsi_pkg::REG_CORNER_AY: csr_prdata = corner_a_ff[1];
         rbsi_pkg::REG_CORNER_AZ: csr_prdata = corner_a_ff[2];
         rbsi_pkg::REG_CORNER_BX: csr_prdata = corner_b_ff[0];
         rbsi_pkg::REG_CORNER_BY: csr_prdata = corner_b_ff[1];
         rbsi_pkg::REG_CORNER_BZ: csr_prdata = corner_b_ff[2];
         rbsi_pkg::REG_RADIUS:    csr_prdata = {1'b0, sphere_radius_ff};
         default:                 csr_prdata = '0;
      endcase
   end

   rbsi_front u_front (
      .shape_is_box (shape_is_box_ff),
      .corner_a     (corner_a_ff),
      .corner_b     (corner_b_ff),
      .req_push     (req_push),
      .req_full     (req_full),
      .origin       ({req_origin_z, req_origin_y, req_origin_x}),
      .dir          ({req_dir_z, req_dir_y, req_dir_x}),
      .q_full       (q_full),
      .q_push       (q_push),
      .item         (item)
   );

   rbsi_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (item),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .head      (q_head)
   );

   rbsi_back #(
      .COORD_FRAC_BITS (COORD_FRAC_BITS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .q_empty      (q_empty),
      .q_head       (q_head),
      .q_pop        (q_pop),
      .radius       (sphere_radius_ff),
      .rsp_pop      (rsp_pop),
      .rsp_empty    (rsp_empty),
      .rsp_hit      (rsp_hit),
      .rsp_distance (rsp_distance)
   );

endmodule

/* src/rbsi_front.sv */
module rbsi_front (
   input  logic                                  shape_is_box,
   input  logic [2:0][rbsi_pkg::COORD_W-1:0]     corner_a,
   input  logic [2:0][rbsi_pkg::COORD_W-1:0]     corner_b,
   input  logic                                  req_push,
   output logic                                  req_full,
   input  logic [2:0][rbsi_pkg::COORD_W-1:0]     origin,
   input  logic [2:0][rbsi_pkg::DIR_W-1:0]       dir,
   input  logic                                  q_full,
   output logic                                  q_push,
   output rbsi_pkg::item_type                    item
);

   logic [2:0] out_slab;

   assign req_full = q_full;
   assign q_push = req_push && !q_full;

   always_comb begin
      item.is_box = shape_is_box;
      item.dir = dir;
      for (int i = 0; i < 3; i++) begin
         item.da[i] = {corner_a[i][rbsi_pkg::COORD_W-1], corner_a[i]}
                      - {origin[i][rbsi_pkg::COORD_W-1], origin[i]};
         item.db[i] = {corner_b[i][rbsi_pkg::COORD_W-1], corner_b[i]}
                      - {origin[i][rbsi_pkg::COORD_W-1], origin[i]};
         item.par[i] = rbsi_pkg::mag_dir(dir[i]) <= rbsi_pkg::DMAG_W'(rbsi_pkg::PARALLEL_MAX);
         out_slab[i] = ($signed(origin[i]) < $signed(corner_a[i]))
                       || ($signed(origin[i]) > $signed(corner_b[i]));
      end
      // a parallel axis whose slab does not hold the origin rules the box out
      item.par_miss = |(item.par & out_slab);
   end

endmodule

/* src/rbsi_queue.sv */
module rbsi_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  rbsi_pkg::item_type push_item,
   output logic               full,
   input  logic               pop,
   output logic               empty,
   output rbsi_pkg::item_type head
);

   rbsi_pkg::item_type                mem_ff [0:rbsi_pkg::QUEUE_DEPTH-1];
   logic [rbsi_pkg::QPTR_W-1:0]       wr_ff, wr_in;
   logic [rbsi_pkg::QPTR_W-1:0]       rd_ff, rd_in;
   logic [rbsi_pkg::QCNT_W-1:0]       cnt_ff, cnt_in;

   assign full = cnt_ff == rbsi_pkg::QCNT_W'(rbsi_pkg::QUEUE_DEPTH);
   assign empty = cnt_ff == '0;
   assign head = mem_ff[rd_ff];

   always_comb begin
      wr_in = push ? wr_ff + 1'b1 : wr_ff;
      rd_in = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + {{(rbsi_pkg::QCNT_W-1){1'b0}}, push}
               - {{(rbsi_pkg::QCNT_W-1){1'b0}}, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_item;
      end
   end

endmodule

/* src/rbsi_back.sv */
module rbsi_back #(
   parameter int COORD_FRAC_BITS = rbsi_pkg::COORD_FRAC_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              q_empty,
   input  rbsi_pkg::item_type                q_head,
   output logic                              q_pop,
   input  logic [rbsi_pkg::RADIUS_W-1:0]     radius,
   input  logic                              rsp_pop,
   output logic                              rsp_empty,
   output logic                              rsp_hit,
   output logic [rbsi_pkg::DIST_W-1:0]       rsp_distance
);

   localparam int TW = rbsi_pkg::T_W;
   localparam int VW = rbsi_pkg::V_W;
   localparam int TSW = rbsi_pkg::TS_W;
   localparam int HW = rbsi_pkg::HALF_W;
   localparam int L2W = rbsi_pkg::L2_W;
   localparam longint LIMIT_L = 64'sd100000 <<< COORD_FRAC_BITS;
   localparam logic signed [TW-1:0] DIST_LIMIT = TW'(LIMIT_L);

   typedef struct packed {
      logic [2:0][rbsi_pkg::PROD_W-1:0] p;
      logic [2:0][rbsi_pkg::SQ_W-1:0]   sq;
      logic [rbsi_pkg::R2_W-1:0]        r2;
      logic [rbsi_pkg::L2_W-1:0]        l2;
      logic [rbsi_pkg::S_W-1:0]         s;
      logic [rbsi_pkg::MS_W-1:0]        ms;
      logic                             outside;
      logic                             early;
      logic [2*HW-1:0]                  hh;
      logic [2*HW-1:0]                  hl;
      logic [2*HW-1:0]                  ll;
      logic [rbsi_pkg::S2_W-1:0]        s2;
      logic [VW-1:0]                    rs;
      logic [VW-1:0]                    ls;
      logic [VW-1:0]                    v;
      logic                             miss;
   } sph_type;

   typedef struct packed {
      logic [5:0]                         neg;
      logic [5:0][rbsi_pkg::NUM_W-1:0]    q;
   } box_q_type;

   typedef struct packed {
      logic [2:0][TW-1:0] lo;
      logic [2:0][TW-1:0] hi;
   } box_ax_type;

   typedef struct packed {
      logic [TW-1:0] tmin;
      logic [TW-1:0] tmax;
   } box_mm_type;

   typedef struct packed {
      logic                         hit;
      logic [rbsi_pkg::TSH_W-1:0]   t;
   } sph_t_type;

   typedef struct packed {
      logic          hit;
      logic [TW-1:0] len;
   } sph_c_type;

   typedef struct packed {
      logic                        hit;
      logic [rbsi_pkg::DIST_W-1:0] len;
   } res_type;

   logic                     en;
   rbsi_pkg::tag_type        tag_ff [0:rbsi_pkg::ST_LAST];
   rbsi_pkg::item_type       s0_ff;
   rbsi_pkg::div_lane_type   div_init [0:5];
   rbsi_pkg::div_lane_type   div_ff [0:rbsi_pkg::DIV_STEPS-1][0:5];
   box_q_type                bq_in;
   box_q_type                bq_ff [0:rbsi_pkg::BOX_PAD-1];
   sph_type                  sp_in [0:rbsi_pkg::SPH_PRE-1];
   sph_type                  sp_ff [0:rbsi_pkg::SPH_PRE-1];
   rbsi_pkg::sqrt_type       sq_init;
   rbsi_pkg::sqrt_type       sq_ff [0:rbsi_pkg::SQRT_STEPS-1];
   box_ax_type               bax_in, bax_ff;
   box_mm_type               bmm_in, bmm_ff;
   sph_t_type                spt_in, spt_ff;
   sph_c_type                spc_in, spc_ff;
   res_type                  res_in, res_ff;

   res_type                  oq_ff [0:1];
   logic                     oq_wr_ff, oq_rd_ff;
   logic [1:0]               oq_cnt_ff, oq_cnt_in;
   logic                     oq_push, oq_pop;

   // the whole pipe moves together while the result queue has room
   assign en = oq_cnt_ff != 2'd2;
   assign q_pop = en && !q_empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= rbsi_pkg::ST_LAST; k++) begin
            tag_ff[k] <= '0;
         end
      end else if (en) begin
         tag_ff[0] <= '{vld: !q_empty, is_box: q_head.is_box, par: q_head.par,
                        par_miss: q_head.par_miss};
         for (int k = 1; k <= rbsi_pkg::ST_LAST; k++) begin
            tag_ff[k] <= tag_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s0_ff <= q_head;
      end
   end

   // box: six slab divisions, one quotient bit per stage
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         div_init[i].rem = '0;
         div_init[i].nq = {rbsi_pkg::mag_diff(s0_ff.da[i]),
                           {rbsi_pkg::DIR_FRAC_BITS{1'b0}}};
         div_init[i].den = rbsi_pkg::mag_dir(s0_ff.dir[i]);
         div_init[i].neg = s0_ff.da[i][rbsi_pkg::DIFF_W-1] ^ s0_ff.dir[i][rbsi_pkg::DIR_W-1];
         div_init[3+i].rem = '0;
         div_init[3+i].nq = {rbsi_pkg::mag_diff(s0_ff.db[i]),
                             {rbsi_pkg::DIR_FRAC_BITS{1'b0}}};
         div_init[3+i].den = rbsi_pkg::mag_dir(s0_ff.dir[i]);
         div_init[3+i].neg = s0_ff.db[i][rbsi_pkg::DIFF_W-1]
                             ^ s0_ff.dir[i][rbsi_pkg::DIR_W-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int l = 0; l < 6; l++) begin
            div_ff[0][l] <= rbsi_pkg::div_step(div_init[l]);
            for (int j = 1; j < rbsi_pkg::DIV_STEPS; j++) begin
               div_ff[j][l] <= rbsi_pkg::div_step(div_ff[j-1][l]);
            end
         end
      end
   end

   always_comb begin
      for (int l = 0; l < 6; l++) begin
         bq_in.neg[l] = div_ff[rbsi_pkg::DIV_STEPS-1][l].neg;
         bq_in.q[l] = div_ff[rbsi_pkg::DIV_STEPS-1][l].nq;
      end
   end

   // quotients wait here for the sphere path to catch up
   always_ff @(posedge clock) begin
      if (en) begin
         bq_ff[0] <= bq_in;
         for (int k = 1; k < rbsi_pkg::BOX_PAD; k++) begin
            bq_ff[k] <= bq_ff[k-1];
         end
      end
   end

   // sphere front stages
   always_comb begin
      logic [rbsi_pkg::MAG_W-1:0] m;
      logic [rbsi_pkg::S_W-1:0]   sneg;
      sp_in[0] = '0;
      for (int i = 0; i < 3; i++) begin
         m = rbsi_pkg::mag_diff(s0_ff.da[i]);
         sp_in[0].p[i] = $signed(s0_ff.da[i]) * $signed(s0_ff.dir[i]);
         sp_in[0].sq[i] = m * m;
      end
      sp_in[0].r2 = radius * radius;

      sp_in[1] = sp_ff[0];
      sp_in[1].s = rbsi_pkg::S_W'($signed(sp_ff[0].p[0]))
                   + rbsi_pkg::S_W'($signed(sp_ff[0].p[1]))
                   + rbsi_pkg::S_W'($signed(sp_ff[0].p[2]));
      sp_in[1].l2 = L2W'(sp_ff[0].sq[0]) + L2W'(sp_ff[0].sq[1]) + L2W'(sp_ff[0].sq[2]);

      sp_in[2] = sp_ff[1];
      sneg = ~sp_ff[1].s + 1'b1;
      sp_in[2].ms = sp_ff[1].s[rbsi_pkg::S_W-1] ? sneg[rbsi_pkg::MS_W-1:0]
                                                : sp_ff[1].s[rbsi_pkg::MS_W-1:0];
      sp_in[2].outside = L2W'(sp_ff[1].r2) < sp_ff[1].l2;

      sp_in[3] = sp_ff[2];
      sp_in[3].hh = sp_ff[2].ms[2*HW-1:HW] * sp_ff[2].ms[2*HW-1:HW];
      sp_in[3].hl = sp_ff[2].ms[2*HW-1:HW] * sp_ff[2].ms[HW-1:0];
      sp_in[3].ll = sp_ff[2].ms[HW-1:0] * sp_ff[2].ms[HW-1:0];
      sp_in[3].early = sp_ff[2].s[rbsi_pkg::S_W-1] && sp_ff[2].outside;

      sp_in[4] = sp_ff[3];
      sp_in[4].s2 = (rbsi_pkg::S2_W'(sp_ff[3].hh) << (2*HW))
                    + (rbsi_pkg::S2_W'(sp_ff[3].hl) << (HW+1))
                    + rbsi_pkg::S2_W'(sp_ff[3].ll);

      sp_in[5] = sp_ff[4];
      sp_in[5].rs = (VW'(sp_ff[4].r2) << rbsi_pkg::RS_SHIFT) + sp_ff[4].s2;
      sp_in[5].ls = VW'(sp_ff[4].l2) << rbsi_pkg::RS_SHIFT;

      sp_in[6] = sp_ff[5];
      sp_in[6].v = sp_ff[5].rs - sp_ff[5].ls;
      sp_in[6].miss = sp_ff[5].early || (sp_ff[5].rs < sp_ff[5].ls);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < rbsi_pkg::SPH_PRE; k++) begin
            sp_ff[k] <= sp_in[k];
         end
      end
   end

   always_comb begin
      sq_init.rem = '0;
      sq_init.root = '0;
      sq_init.v = sp_ff[rbsi_pkg::SPH_PRE-1].v;
      sq_init.s = sp_ff[rbsi_pkg::SPH_PRE-1].s;
      sq_init.outside = sp_ff[rbsi_pkg::SPH_PRE-1].outside;
      sq_init.miss = sp_ff[rbsi_pkg::SPH_PRE-1].miss;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sq_ff[0] <= rbsi_pkg::sqrt_step(sq_init);
         for (int j = 1; j < rbsi_pkg::SQRT_STEPS; j++) begin
            sq_ff[j] <= rbsi_pkg::sqrt_step(sq_ff[j-1]);
         end
      end
   end

   // signed slab distances and sphere distance
   always_comb begin
      logic signed [TW-1:0]  ta;
      logic signed [TW-1:0]  tb;
      logic signed [TSW-1:0] ts;
      logic signed [TSW-1:0] tr;
      logic signed [TSW-1:0] t;
      rbsi_pkg::sqrt_type    sl;
      for (int i = 0; i < 3; i++) begin
         ta = TW'(bq_ff[rbsi_pkg::BOX_PAD-1].q[i]);
         tb = TW'(bq_ff[rbsi_pkg::BOX_PAD-1].q[3+i]);
         if (bq_ff[rbsi_pkg::BOX_PAD-1].neg[i]) begin
            ta = -ta;
         end
         if (bq_ff[rbsi_pkg::BOX_PAD-1].neg[3+i]) begin
            tb = -tb;
         end
         bax_in.lo[i] = (ta > tb) ? tb : ta;
         bax_in.hi[i] = (ta > tb) ? ta : tb;
      end
      sl = sq_ff[rbsi_pkg::SQRT_STEPS-1];
      ts = TSW'($signed(sl.s));
      tr = {{(TSW-rbsi_pkg::ROOT_W){1'b0}}, sl.root};
      t = sl.outside ? ts - tr : ts + tr;
      // dropping the fraction bits of a signed value rounds toward minus infinity
      spt_in.t = t[TSW-1:rbsi_pkg::DIR_FRAC_BITS];
      spt_in.hit = !sl.miss;
   end

   always_comb begin
      logic signed [TW-1:0] tmin;
      logic signed [TW-1:0] tmax;
      logic signed [TW-1:0] tx;
      tmin = '0;
      tmax = DIST_LIMIT;
      for (int i = 0; i < 3; i++) begin
         if (!tag_ff[rbsi_pkg::ST_ROOT+1].par[i]) begin
            if ($signed(bax_ff.lo[i]) > tmin) begin
               tmin = bax_ff.lo[i];
            end
            if ($signed(bax_ff.hi[i]) < tmax) begin
               tmax = bax_ff.hi[i];
            end
         end
      end
      bmm_in.tmin = tmin;
      bmm_in.tmax = tmax;
      tx = TW'($signed(spt_ff.t));
      if (tx < 0) begin
         spc_in.len = '0;
      end else if (tx > DIST_LIMIT) begin
         spc_in.len = DIST_LIMIT;
      end else begin
         spc_in.len = tx;
      end
      spc_in.hit = spt_ff.hit;
   end

   always_comb begin
      logic          bhit;
      logic [TW-1:0] bdist;
      bhit = !tag_ff[rbsi_pkg::ST_ROOT+2].par_miss
             && !($signed(bmm_ff.tmax) < $signed(bmm_ff.tmin));
      bdist = ($signed(bmm_ff.tmin) > 0) ? bmm_ff.tmin : bmm_ff.tmax;
      if (tag_ff[rbsi_pkg::ST_ROOT+2].is_box) begin
         res_in.hit = bhit;
         res_in.len = bhit ? bdist[rbsi_pkg::DIST_W-1:0] : '0;
      end else begin
         res_in.hit = spc_ff.hit;
         res_in.len = spc_ff.hit ? spc_ff.len[rbsi_pkg::DIST_W-1:0] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         bax_ff <= bax_in;
         spt_ff <= spt_in;
         bmm_ff <= bmm_in;
         spc_ff <= spc_in;
         res_ff <= res_in;
      end
   end

   // two-entry result queue
   assign oq_push = en && tag_ff[rbsi_pkg::ST_LAST].vld;
   assign oq_pop = rsp_pop && (oq_cnt_ff != 2'd0);
   assign oq_cnt_in = oq_cnt_ff + {1'b0, oq_push} - {1'b0, oq_pop};
   assign rsp_empty = oq_cnt_ff == 2'd0;
   assign rsp_hit = oq_ff[oq_rd_ff].hit;
   assign rsp_distance = oq_ff[oq_rd_ff].len;

   always_ff @(posedge clock) begin
      if (reset) begin
         oq_wr_ff <= 1'b0;
         oq_rd_ff <= 1'b0;
         oq_cnt_ff <= 2'd0;
      end else begin
         oq_wr_ff <= oq_wr_ff ^ oq_push;
         oq_rd_ff <= oq_rd_ff ^ oq_pop;
         oq_cnt_ff <= oq_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (oq_push) begin
         oq_ff[oq_wr_ff] <= res_ff;
      end
   end

endmodule
